// File: hdl/size_class_block_recycler_assert.svh
// Assertion macros shared by the recycler RTL.
`ifndef SIZE_CLASS_BLOCK_RECYCLER_ASSERT_SVH
`define SIZE_CLASS_BLOCK_RECYCLER_ASSERT_SVH

`ifndef NO_ASSERTIONS
`define SCBR_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define SCBR_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define SCBR_ASSERT(lbl, prop, msg)
`define SCBR_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

// File: hdl/scbr_pkg.sv
// Types and constants of the size class block recycler.
package scbr_pkg;

    localparam int HINT_W   = 4;
    localparam int SIZE_W   = 24;
    localparam int ADDR_W   = 32;
    localparam int STATUS_W = 3;

    localparam logic [HINT_W-1:0] NO_HINT = 4'd8;

    typedef enum logic
    {
        OP_ALLOC,
        OP_FREE
    } op_t;

    typedef enum logic [STATUS_W-1:0]
    {
        STAT_CACHED_OUT = 3'd0,
        STAT_POOL_ALLOC = 3'd1,
        STAT_STORED     = 3'd2,
        STAT_RELEASE    = 3'd3,
        STAT_NOT_FOUND  = 3'd4,
        STAT_BAD        = 3'd5
    } status_t;

    typedef enum logic [2:0]
    {
        S_IDLE,
        S_EVAL,
        S_SEARCH,
        S_ACT,
        S_READ,
        S_DONE
    } state_t;

endpackage

// File: hdl/scbr_if.sv
// Request and response channel interfaces of the recycler.
interface scbr_req_if
    import scbr_pkg::*;
();
    logic              valid;
    logic              ready;
    op_t               opcode;
    logic [HINT_W-1:0] class_hint;
    logic [SIZE_W-1:0] block_size;
    logic [ADDR_W-1:0] block_address;

    modport source (output valid, opcode, class_hint, block_size, block_address,
                    input ready);
    modport sink (input valid, opcode, class_hint, block_size, block_address,
                  output ready);
endinterface

interface scbr_rsp_if
    import scbr_pkg::*;
();
    logic              valid;
    logic              ready;
    status_t           status;
    logic [ADDR_W-1:0] out_address;
    logic [HINT_W-1:0] class_index;

    modport source (output valid, status, out_address, class_index, input ready);
    modport sink (input valid, status, out_address, class_index, output ready);
endinterface

// File: hdl/size_class_block_recycler.sv
// Size class block recycler: per-class LIFO caches of freed block addresses.
// One request is handled at a time by a small sequencer around one shared size
// comparator and one single-port address memory. A request with a valid class hint
// goes from S_EVAL to S_ACT, and an allocate that pops a cached address then passes
// S_READ, because of the registered memory read, before S_DONE loads the response
// into the output register. A bad hint or a free with no hint and size zero goes from
// S_EVAL straight to S_DONE. Without a hint, the serial size search S_SEARCH compares
// the classes in use one at a time and may end by adding a new class. Ready returns
// on the edge that loads the response. A response that is not taken holds the next
// one in the sequencer until it is.
module size_class_block_recycler
    import scbr_pkg::*;
#(
    parameter int NUM_CLASSES = 8,
    parameter int MAX_CACHED  = 16,
    parameter int ADDR_WIDTH  = 32
)
(
    input  logic       clk,
    input  logic       rst_n,
    scbr_req_if.sink   req,
    scbr_rsp_if.source rsp
);

    localparam int CW        = $clog2(NUM_CLASSES + 1);
    localparam int IW        = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;
    localparam int FW        = $clog2(MAX_CACHED + 1);
    localparam int SW        = (ADDR_WIDTH < ADDR_W) ? ADDR_WIDTH : ADDR_W;
    localparam int MEM_DEPTH = NUM_CLASSES * MAX_CACHED;
    localparam int AW        = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;
    localparam int CMP_W     = (CW > HINT_W) ? CW : HINT_W;

    state_t              state_reg, state_next;
    op_t                 op_reg, op_next;
    logic [HINT_W-1:0]   hint_reg, hint_next;
    logic [SIZE_W-1:0]   size_reg, size_next;
    logic [SW-1:0]       addr_reg, addr_next;
    logic [CW-1:0]       count_reg, count_next;
    logic [CW-1:0]       idx_reg, idx_next;
    logic [IW-1:0]       n_reg, n_next;
    logic [SIZE_W-1:0]   class_size_reg [NUM_CLASSES];
    logic [SIZE_W-1:0]   class_size_next [NUM_CLASSES];
    logic [FW-1:0]       class_fill_reg [NUM_CLASSES];
    logic [FW-1:0]       class_fill_next [NUM_CLASSES];
    status_t             res_status_reg, res_status_next;
    logic [ADDR_W-1:0]   res_addr_reg, res_addr_next;
    logic [HINT_W-1:0]   res_class_reg, res_class_next;
    logic                out_valid_reg, out_valid_next;
    status_t             out_status_reg, out_status_next;
    logic [ADDR_W-1:0]   out_addr_reg, out_addr_next;
    logic [HINT_W-1:0]   out_class_reg, out_class_next;

    logic [SW-1:0]       cache_mem [MEM_DEPTH];
    logic [SW-1:0]       rd_data_reg;
    logic [AW-1:0]       mem_addr;
    logic                mem_we;
    logic [FW-1:0]       slot;
    logic [FW-1:0]       cur_fill;
    logic                size_match;
    logic [CW-1:0]       count_inc;
    logic                rsp_failed;

    assign req.ready       = (state_reg == S_IDLE);
    assign rsp.valid       = out_valid_reg;
    assign rsp.status      = out_status_reg;
    assign rsp.out_address = out_addr_reg;
    assign rsp.class_index = out_class_reg;

    assign cur_fill   = class_fill_reg[n_reg];
    assign size_match = (class_size_reg[idx_reg[IW-1:0]] == size_reg);
    assign slot       = (op_reg == OP_ALLOC) ? (cur_fill - FW'(1)) : cur_fill;
    assign mem_addr   = AW'(int'(n_reg) * MAX_CACHED + int'(slot));
    assign count_inc  = count_reg + CW'(1);
    assign rsp_failed = out_valid_reg &&
                        (out_status_reg == STAT_NOT_FOUND || out_status_reg == STAT_BAD);

    always_comb
    begin
        state_next      = state_reg;
        op_next         = op_reg;
        hint_next       = hint_reg;
        size_next       = size_reg;
        addr_next       = addr_reg;
        count_next      = count_reg;
        idx_next        = idx_reg;
        n_next          = n_reg;
        class_size_next = class_size_reg;
        class_fill_next = class_fill_reg;
        res_status_next = res_status_reg;
        res_addr_next   = res_addr_reg;
        res_class_next  = res_class_reg;
        out_valid_next  = out_valid_reg && !rsp.ready;
        out_status_next = out_status_reg;
        out_addr_next   = out_addr_reg;
        out_class_next  = out_class_reg;
        mem_we          = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    op_next    = req.opcode;
                    hint_next  = req.class_hint;
                    size_next  = req.block_size;
                    addr_next  = req.block_address[SW-1:0];
                    state_next = S_EVAL;
                end
            end
            S_EVAL:
            begin
                res_addr_next  = '0;
                res_class_next = NO_HINT;
                idx_next       = '0;
                if (hint_reg != NO_HINT)
                begin
                    if ((CMP_W'(hint_reg) >= CMP_W'(count_reg)) ||
                        (CMP_W'(hint_reg) >= CMP_W'(NUM_CLASSES)))
                    begin
                        res_status_next = STAT_BAD;
                        state_next      = S_DONE;
                    end
                    else
                    begin
                        n_next     = IW'(hint_reg);
                        state_next = S_ACT;
                    end
                end
                else if ((op_reg == OP_FREE) && (size_reg == '0))
                begin
                    res_status_next = STAT_RELEASE;
                    state_next      = S_DONE;
                end
                else
                begin
                    state_next = S_SEARCH;
                end
            end
            S_SEARCH:
            begin
                if (idx_reg < count_reg)
                begin
                    if (size_match)
                    begin
                        n_next     = idx_reg[IW-1:0];
                        state_next = S_ACT;
                    end
                    else
                    begin
                        idx_next = idx_reg + CW'(1);
                    end
                end
                else if (op_reg == OP_FREE)
                begin
                    res_status_next = STAT_NOT_FOUND;
                    state_next      = S_DONE;
                end
                else if (count_reg >= CW'(NUM_CLASSES))
                begin
                    res_status_next = STAT_BAD;
                    state_next      = S_DONE;
                end
                else
                begin
                    class_size_next[count_reg[IW-1:0]] = size_reg;
                    class_fill_next[count_reg[IW-1:0]] = '0;
                    n_next     = count_reg[IW-1:0];
                    count_next = count_inc;
                    state_next = S_ACT;
                end
            end
            S_ACT:
            begin
                res_class_next = HINT_W'(n_reg);
                if (op_reg == OP_ALLOC)
                begin
                    if (cur_fill != '0)
                    begin
                        class_fill_next[n_reg] = slot;
                        res_status_next        = STAT_CACHED_OUT;
                        state_next             = S_READ;
                    end
                    else
                    begin
                        res_status_next = STAT_POOL_ALLOC;
                        state_next      = S_DONE;
                    end
                end
                else if (cur_fill < FW'(MAX_CACHED))
                begin
                    mem_we                 = 1'b1;
                    class_fill_next[n_reg] = cur_fill + FW'(1);
                    res_status_next        = STAT_STORED;
                    state_next             = S_DONE;
                end
                else
                begin
                    res_status_next = STAT_RELEASE;
                    state_next      = S_DONE;
                end
            end
            S_READ:
            begin
                res_addr_next = ADDR_W'(rd_data_reg);
                state_next    = S_DONE;
            end
            S_DONE:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = res_status_reg;
                    out_addr_next   = res_addr_reg;
                    out_class_next  = res_class_reg;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            count_reg      <= '0;
            out_valid_reg  <= 1'b0;
            class_fill_reg <= '{default: '0};
        end
        else
        begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            out_valid_reg  <= out_valid_next;
            class_fill_reg <= class_fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg         <= op_next;
        hint_reg       <= hint_next;
        size_reg       <= size_next;
        addr_reg       <= addr_next;
        idx_reg        <= idx_next;
        n_reg          <= n_next;
        class_size_reg <= class_size_next;
        res_status_reg <= res_status_next;
        res_addr_reg   <= res_addr_next;
        res_class_reg  <= res_class_next;
        out_status_reg <= out_status_next;
        out_addr_reg   <= out_addr_next;
        out_class_reg  <= out_class_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            cache_mem[mem_addr] <= addr_reg;
        end
        rd_data_reg <= cache_mem[mem_addr];
    end

`include "size_class_block_recycler_assert.svh"

    `SCBR_ASSERT_ALWAYS(a_count_bound, !rst_n || count_reg <= CW'(NUM_CLASSES), "count overflow")
    `SCBR_ASSERT(a_count_step, $changed(count_reg) |-> count_reg == $past(count_inc), "count jump")
    `SCBR_ASSERT(a_fill_bound, state_reg == S_ACT |-> cur_fill <= FW'(MAX_CACHED), "fill over limit")
    `SCBR_ASSERT(a_fail_class, rsp_failed |-> out_class_reg == NO_HINT, "failure with a class")
    `SCBR_ASSERT(a_fail_addr, rsp_failed |-> out_addr_reg == '0, "failure with an address")

endmodule

// File: verif/scbr_recycle_checker.sv
`timescale 1ns / 100ps
// Checker that predicts the recycler's responses from the request stream and compares them.
module scbr_recycle_checker
    import scbr_pkg::*;
#(
    parameter int NCLS  = 8,
    parameter int DEPTH = 16
)
(
    input  logic       clk,
    input  logic       rst_n,
    scbr_req_if        req,
    scbr_rsp_if        rsp,
    output int         fail_count,
    output int         outstanding,
    output int         checked,
    output logic [5:0] statuses_seen,
    output int         live_classes
);

    typedef struct packed
    {
        status_t           status;
        logic [ADDR_W-1:0] addr;
        logic [HINT_W-1:0] cls;
    } reply_t;

    logic [SIZE_W-1:0] class_size [NCLS];
    int                class_depth [NCLS];
    logic [ADDR_W-1:0] cached_blocks [NCLS][DEPTH];
    reply_t            expected_replies [$];

    initial
    begin
        fail_count    = 0;
        outstanding   = 0;
        checked       = 0;
        statuses_seen = '0;
        live_classes  = 0;
        for (int i = 0; i < NCLS; i++)
        begin
            class_depth[i] = 0;
        end
    end

    function automatic int size_lookup(logic [SIZE_W-1:0] size);
        for (int i = 0; i < live_classes; i++)
        begin
            if (class_size[i] == size)
            begin
                return i;
            end
        end
        return -1;
    endfunction

    function automatic reply_t recycle_outcome(op_t op, logic [HINT_W-1:0] hint,
                                               logic [SIZE_W-1:0] size,
                                               logic [ADDR_W-1:0] addr);
        reply_t r;
        int     n;
        r.status = STAT_BAD;
        r.addr   = '0;
        r.cls    = NO_HINT;
        n        = -1;
        if (hint != NO_HINT)
        begin
            if (int'(hint) < live_classes)
            begin
                n = int'(hint);
            end
        end
        else if (op == OP_ALLOC)
        begin
            n = size_lookup(size);
            if (n < 0 && live_classes < NCLS)
            begin
                n = live_classes;
                class_size[n] = size;
                class_depth[n] = 0;
                live_classes = live_classes + 1;
            end
        end
        else if (size == '0)
        begin
            r.status = STAT_RELEASE;
        end
        else
        begin
            n = size_lookup(size);
            if (n < 0)
            begin
                r.status = STAT_NOT_FOUND;
            end
        end
        if (n >= 0)
        begin
            r.cls = HINT_W'(n);
            if (op == OP_ALLOC)
            begin
                if (class_depth[n] > 0)
                begin
                    class_depth[n] = class_depth[n] - 1;
                    r.status = STAT_CACHED_OUT;
                    r.addr   = cached_blocks[n][class_depth[n]];
                end
                else
                begin
                    r.status = STAT_POOL_ALLOC;
                end
            end
            else if (class_depth[n] < DEPTH)
            begin
                cached_blocks[n][class_depth[n]] = addr;
                class_depth[n] = class_depth[n] + 1;
                r.status = STAT_STORED;
            end
            else
            begin
                r.status = STAT_RELEASE;
            end
        end
        return r;
    endfunction

    always @(posedge clk)
    begin
        reply_t want;
        if (rst_n)
        begin
            if (rsp.valid && rsp.ready)
            begin
                if (expected_replies.size() == 0)
                begin
                    $display("%0t: unexpected response: status %0d addr %h class %0d",
                             $time, rsp.status, rsp.out_address, rsp.class_index);
                    fail_count = fail_count + 1;
                end
                else
                begin
                    want = expected_replies.pop_front();
                    checked = checked + 1;
                    if (rsp.status !== want.status || rsp.out_address !== want.addr ||
                        rsp.class_index !== want.cls)
                    begin
                        $display("%0t: mismatch: expected status %0d addr %h class %0d, got status %0d addr %h class %0d",
                                 $time, want.status, want.addr, want.cls,
                                 rsp.status, rsp.out_address, rsp.class_index);
                        fail_count = fail_count + 1;
                    end
                    else
                    begin
                        statuses_seen[want.status] = 1'b1;
                    end
                end
            end
            if (req.valid && req.ready)
            begin
                expected_replies.push_back(recycle_outcome(req.opcode, req.class_hint,
                                                           req.block_size,
                                                           req.block_address));
            end
            outstanding = expected_replies.size();
        end
    end

endmodule

// File: verif/tb_top.sv
`timescale 1ns / 100ps
// Top-level testbench of the size class block recycler: clock, reset, stimulus and verdict.
module tb_top;
    import scbr_pkg::*;

    localparam int N_RANDOM   = 1950;
    localparam int BLOCK_LEN  = 50;
    localparam int QUIET_TAIL = 200;

    logic       clk = 1'b0;
    logic       rst_n;
    bit         idle_on;
    int         fail_count;
    int         outstanding;
    int         checked;
    int         issued;
    int         live_classes;
    logic [5:0] statuses_seen;
    logic [SIZE_W-1:0] class_sizes [8];

    scbr_req_if req();
    scbr_rsp_if rsp();

    size_class_block_recycler i_dut
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp)
    );

    scbr_recycle_checker #(.NCLS(8), .DEPTH(16)) i_checker
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .req           (req),
        .rsp           (rsp),
        .fail_count    (fail_count),
        .outstanding   (outstanding),
        .checked       (checked),
        .statuses_seen (statuses_seen),
        .live_classes  (live_classes)
    );

    always #2 clk = ~clk;

    task automatic issue_request(input op_t op, input logic [HINT_W-1:0] hint,
                                 input logic [SIZE_W-1:0] size,
                                 input logic [ADDR_W-1:0] addr);
        int gap;
        if (idle_on && $urandom_range(0, 2) == 0)
        begin
            gap = $urandom_range(1, 4);
            req.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        req.valid         <= 1'b1;
        req.opcode        <= op;
        req.class_hint    <= hint;
        req.block_size    <= size;
        req.block_address <= addr;
        @(posedge clk);
        while (!req.ready)
        begin
            @(posedge clk);
        end
        issued = issued + 1;
        @(negedge clk);
    endtask

    initial
    begin
        int n;
        rsp.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            n = $urandom_range(1, 4);
            if (idle_on && $urandom_range(0, 3) == 0)
            begin
                rsp.ready <= 1'b0;
            end
            else
            begin
                rsp.ready <= 1'b1;
            end
            repeat (n) @(negedge clk);
        end
    end

    initial
    begin
        int                free_pct;
        int                focus;
        int                cls;
        int                mode;
        op_t               op;
        logic [HINT_W-1:0] hint;
        logic [SIZE_W-1:0] size;
        logic [ADDR_W-1:0] addr;

        req.valid         = 1'b0;
        req.opcode        = OP_ALLOC;
        req.class_hint    = NO_HINT;
        req.block_size    = '0;
        req.block_address = '0;
        rst_n             = 1'b0;
        idle_on           = 1'b1;
        issued            = 0;
        class_sizes       = '{24'h000000, 24'hFFFFFF, 24'd1, 24'd2,
                              24'd4, 24'd8, 24'd16, 24'd32};
        repeat (8) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        issue_request(OP_ALLOC, 4'd0, 24'd0, 32'h0);
        issue_request(OP_FREE, 4'd15, 24'hFFFFFF, 32'hFFFFFFFF);
        issue_request(OP_FREE, NO_HINT, 24'd0, 32'h12345678);
        issue_request(OP_FREE, NO_HINT, 24'd5, 32'h87654321);
        issue_request(OP_ALLOC, NO_HINT, class_sizes[0], 32'hFFFFFFFF);
        issue_request(OP_FREE, NO_HINT, 24'd0, 32'hDEADBEEF);
        issue_request(OP_FREE, 4'd0, 24'd0, 32'h00000000);
        issue_request(OP_FREE, 4'd0, 24'hFFFFFF, 32'hFFFFFFFF);
        issue_request(OP_ALLOC, 4'd0, 24'd0, 32'h0);
        issue_request(OP_ALLOC, NO_HINT, class_sizes[1], 32'h0);
        issue_request(OP_FREE, NO_HINT, class_sizes[1], 32'hA5A5A5A5);
        issue_request(OP_ALLOC, NO_HINT, class_sizes[1], 32'h5A5A5A5A);
        issue_request(OP_ALLOC, 4'd0, 24'd0, 32'h0);
        issue_request(OP_ALLOC, 4'd0, 24'd0, 32'h0);
        issue_request(OP_ALLOC, 4'd1, 24'd0, 32'h0);
        issue_request(OP_ALLOC, 4'd2, 24'd0, 32'h0);
        for (int i = 2; i < 8; i++)
        begin
            issue_request(OP_ALLOC, NO_HINT, class_sizes[i], $urandom());
        end
        issue_request(OP_ALLOC, NO_HINT, 24'h123456, 32'h0);
        issue_request(OP_FREE, NO_HINT, 24'h123456, 32'h13579BDF);
        issue_request(OP_FREE, 4'd7, 24'd0, 32'h2468ACE0);

        for (int blk = 0; blk < N_RANDOM / BLOCK_LEN; blk++)
        begin
            case ($urandom_range(0, 2))
                0: free_pct = 15;
                1: free_pct = 50;
                default: free_pct = 90;
            endcase
            focus = $urandom_range(0, 7);
            for (int k = 0; k < BLOCK_LEN; k++)
            begin
                if (blk * BLOCK_LEN + k >= N_RANDOM - QUIET_TAIL)
                begin
                    idle_on = 1'b0;
                end
                op   = ($urandom_range(0, 99) < free_pct) ? OP_FREE : OP_ALLOC;
                cls  = ($urandom_range(0, 9) < 7) ? focus : $urandom_range(0, 7);
                mode = $urandom_range(0, 19);
                size = SIZE_W'($urandom());
                addr = $urandom();
                hint = HINT_W'(cls);
                if (mode < 7)
                begin
                    hint = NO_HINT;
                    size = class_sizes[cls];
                end
                else if (mode == 7)
                begin
                    hint = HINT_W'($urandom_range(9, 15));
                end
                else if (mode == 8)
                begin
                    hint = NO_HINT;
                end
                else if (mode == 9)
                begin
                    hint = NO_HINT;
                    size = '0;
                end
                issue_request(op, hint, size, addr);
            end
        end
        req.valid <= 1'b0;

        while (outstanding != 0)
        begin
            @(negedge clk);
        end
        repeat (40) @(negedge clk);

        $display("Checked %0d responses to %0d allocate and free requests, %0d classes in use.",
                 checked, issued, live_classes);
        $display("Response codes observed, one bit per code: %b", statuses_seen);
        if (fail_count == 0)
        begin
            $display("tb: success");
        end
        else
        begin
            $display("tb: failure");
        end
        $finish;
    end

    initial
    begin
        #(2_000_000);
        $display("tb: failure");
        $finish;
    end

endmodule
